// ===== rtl/boot_stream_frame_receiver_core_defines.svh =====
// assertion helpers for the receiver rtl, used by the request queue
// each expects clk and rst_n in the scope where it is used
`ifndef BOOT_STREAM_FRAME_RECEIVER_CORE_DEFINES_SVH
`define BOOT_STREAM_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define BSFR_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsfr same-cycle check failed");

// next-cycle implication
`define BSFR_CHECK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsfr next-cycle check failed");

`endif

// ===== rtl/bsfr_pkg.sv =====
package bsfr_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MAGIC    = 2'd0;
    localparam logic [1:0] REG_MAX_SIZE = 2'd1;
    localparam logic [1:0] REG_BASE     = 2'd2;

    localparam logic [31:0] RST_MAGIC    = 32'h544F_4F42;
    localparam logic [31:0] RST_MAX_SIZE = 32'h0100_0000;
    localparam logic [31:0] RST_BASE     = 32'h0020_0000;

    localparam logic [3:0] HDR_BYTES = 4'd12;

    // result status codes
    localparam logic [2:0] ST_HEADER   = 3'd0;
    localparam logic [2:0] ST_PAYLOAD  = 3'd1;
    localparam logic [2:0] ST_BADMAGIC = 3'd2;
    localparam logic [2:0] ST_BADSIZE  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_COMPLETE = 3'd5;

    typedef enum logic [2:0] {
        CMD_HDR,
        CMD_HDR_OK,
        CMD_BAD_MAGIC,
        CMD_BAD_SIZE,
        CMD_PAYLOAD,
        CMD_LAST
    } cmd_kind_t;

    // one classified request from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [31:0] word;   // magic, size or check word depending on kind
    } cmd_t;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [31:0] max_size;
        logic [31:0] load_base;
    } cfg_t;

endpackage

// ===== rtl/bsfr_front.sv =====
module bsfr_front
    import bsfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] expected_magic,
    input  logic [31:0] max_size,
    input  logic        take,
    input  logic [7:0]  rx_byte,
    output cmd_t        cmd
);

    logic        in_payload_reg, in_payload_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] check_reg, check_next;
    logic [31:0] left_reg, left_next;

    logic [3:0]  k;
    logic [3:0]  k_inc;

    always_comb
    begin
        k = (hcount_reg > 4'd11) ? 4'd0 : hcount_reg;
        k_inc = k + 4'd1;
        magic_next = magic_reg;
        size_next = size_reg;
        check_next = check_reg;
        in_payload_next = in_payload_reg;
        hcount_next = hcount_reg;
        left_next = left_reg;
        cmd.kind = CMD_HDR;
        cmd.data = rx_byte;
        cmd.word = '0;

        if (!in_payload_reg)
        begin
            case (k[3:2])
                2'd0:    magic_next[{k[1:0], 3'b000} +: 8] = rx_byte;
                2'd1:    size_next[{k[1:0], 3'b000} +: 8] = rx_byte;
                default: check_next[{k[1:0], 3'b000} +: 8] = rx_byte;
            endcase
            if (k_inc < HDR_BYTES)
            begin
                hcount_next = k_inc;
            end
            else if (magic_next != expected_magic)
            begin
                cmd.kind = CMD_BAD_MAGIC;
                cmd.word = magic_next;
                hcount_next = '0;
                left_next = '0;
            end
            else if (size_next == 32'd0 || size_next > max_size)
            begin
                cmd.kind = CMD_BAD_SIZE;
                cmd.word = size_next;
                hcount_next = '0;
                left_next = '0;
            end
            else
            begin
                cmd.kind = CMD_HDR_OK;
                cmd.word = check_next;
                in_payload_next = 1'b1;
                hcount_next = '0;
                left_next = size_next;
            end
        end
        else
        begin
            left_next = left_reg - 32'd1;
            if (left_reg == 32'd1)
            begin
                cmd.kind = CMD_LAST;
                in_payload_next = 1'b0;
                hcount_next = '0;
            end
            else
            begin
                cmd.kind = CMD_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            hcount_reg <= '0;
            magic_reg <= '0;
            size_reg <= '0;
            check_reg <= '0;
            left_reg <= '0;
        end
        else if (take)
        begin
            in_payload_reg <= in_payload_next;
            hcount_reg <= hcount_next;
            magic_reg <= magic_next;
            size_reg <= size_next;
            check_reg <= check_next;
            left_reg <= left_next;
        end
    end

endmodule

// ===== rtl/bsfr_queue.sv =====
`include "boot_stream_frame_receiver_core_defines.svh"

module bsfr_queue
    import bsfr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `BSFR_CHECK_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `BSFR_CHECK_NXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))
    `BSFR_CHECK_NXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))
    `BSFR_CHECK_IMP(a_ptr_agree, empty, wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== rtl/bsfr_back.sv =====
module bsfr_back
    import bsfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] load_base,
    input  cmd_t        cmd,
    input  logic        cmd_avail,
    output logic        cmd_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        write_valid,
    output logic [31:0] write_addr,
    output logic [7:0]  write_data,
    output logic [31:0] detail_word,
    output logic        frame_end
);

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic        wv_reg, wv_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [31:0] detail_reg, detail_next;
    logic        last_reg, last_next;
    logic [31:0] wp_reg, wp_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] check_reg, check_next;
    logic [31:0] sum_add;

    // output register free or being emptied this cycle
    assign cmd_pop = cmd_avail && (!out_valid_reg || out_ready);
    assign sum_add = sum_reg + {24'd0, cmd.data};

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        wv_next = wv_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        detail_next = detail_reg;
        last_next = last_reg;
        wp_next = wp_reg;
        sum_next = sum_reg;
        check_next = check_reg;
        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
            status_next = ST_HEADER;
            wv_next = 1'b0;
            addr_next = '0;
            data_next = '0;
            detail_next = '0;
            last_next = 1'b0;
            case (cmd.kind)
                CMD_HDR:
                begin
                end
                CMD_HDR_OK:
                begin
                    wp_next = load_base;
                    sum_next = '0;
                    check_next = cmd.word;
                end
                CMD_BAD_MAGIC:
                begin
                    status_next = ST_BADMAGIC;
                    detail_next = cmd.word;
                    last_next = 1'b1;
                    sum_next = '0;
                end
                CMD_BAD_SIZE:
                begin
                    status_next = ST_BADSIZE;
                    detail_next = cmd.word;
                    last_next = 1'b1;
                    sum_next = '0;
                end
                CMD_PAYLOAD:
                begin
                    status_next = ST_PAYLOAD;
                    wv_next = 1'b1;
                    addr_next = wp_reg;
                    data_next = cmd.data;
                    wp_next = wp_reg + 32'd1;
                    sum_next = sum_add;
                end
                CMD_LAST:
                begin
                    status_next = (sum_add == check_reg) ? ST_COMPLETE : ST_MISMATCH;
                    wv_next = 1'b1;
                    addr_next = wp_reg;
                    data_next = cmd.data;
                    detail_next = sum_add;
                    last_next = 1'b1;
                    wp_next = wp_reg + 32'd1;
                    sum_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        wv_reg <= wv_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        detail_reg <= detail_next;
        last_reg <= last_next;
        wp_reg <= wp_next;
        sum_reg <= sum_next;
        check_reg <= check_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign write_valid = wv_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;
    assign detail_word = detail_reg;
    assign frame_end = last_reg;

endmodule

// ===== rtl/boot_stream_frame_receiver_core.sv =====
// framed serial loader receiver
// s_axis takes one received byte per request; every byte yields exactly one
// result request on m_axis. a frame is a 12-byte header (little-endian magic,
// size, checksum words) followed by size payload bytes. payload results carry
// a memory write (write_valid, write_addr, write_data); the byte ending an
// attempt raises tlast with status bad magic, bad size, mismatch or complete.
// a byte's result is registered first in a request queue slot and then in the
// output register that drives m_axis
// throughput: one byte per cycle while s_axis_tready is high, set by the front
// classifier and the back 32-bit sum/address update
// a small request queue sits between front and back, so s_axis keeps taking
// bytes while m_axis is stalled until the queue fills; then s_axis_tready
// drops until the receiver takes results again. nothing is dropped
// configuration: cfg_we writes register cfg_index (0 magic, 1 max size,
// 2 load base) at the clock edge; write only while the block is idle
// reset: registers return to their defaults, header collection restarts,
// queue and output register are emptied
module boot_stream_frame_receiver_core
    import bsfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,    // [31:0] write_addr, [39:32] write_data,
                                         // [71:40] detail_word
    output logic [7:0]  m_axis_tuser,    // [2:0] status, [3] write_valid, rest zero
    output logic        m_axis_tlast     // frame_end
);

    cfg_t cfg_reg;

    // request queue handshake
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_empty;
    logic q_full;
    logic q_push;
    logic q_pop;

    logic [2:0]  status;
    logic        write_valid;
    logic [31:0] write_addr;
    logic [7:0]  write_data;
    logic [31:0] detail_word;

    // configuration registers, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic <= RST_MAGIC;
            cfg_reg.max_size <= RST_MAX_SIZE;
            cfg_reg.load_base <= RST_BASE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAGIC:    cfg_reg.expected_magic <= cfg_wdata;
                REG_MAX_SIZE: cfg_reg.max_size <= cfg_wdata;
                REG_BASE:     cfg_reg.load_base <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push = s_axis_tvalid && !q_full;

    // front: header assembly, header check, payload byte counting
    bsfr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .expected_magic (cfg_reg.expected_magic),
        .max_size       (cfg_reg.max_size),
        .take           (q_push),
        .rx_byte        (s_axis_tdata),
        .cmd            (front_cmd)
    );

    bsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: write address, running sum, checksum compare, output register
    bsfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_base   (cfg_reg.load_base),
        .cmd         (head_cmd),
        .cmd_avail   (!q_empty),
        .cmd_pop     (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .write_valid (write_valid),
        .write_addr  (write_addr),
        .write_data  (write_data),
        .detail_word (detail_word),
        .frame_end   (m_axis_tlast)
    );

    assign m_axis_tdata = {detail_word, write_data, write_addr};
    assign m_axis_tuser = {4'd0, write_valid, status};

endmodule
